[src/point_approach_velocity_controller_defines.svh]
// ---------------------------------------------------------------------------
// Point approach velocity controller: assertion macros
// Shared property macros. They compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef POINT_APPROACH_VELOCITY_CONTROLLER_DEFINES_SVH
`define POINT_APPROACH_VELOCITY_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define PAVC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pavc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PAVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pavc assertion failed");

`else

`define PAVC_ASSERT_NOW(lbl, clk, rstn, ante, cons)

`define PAVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/pavc_pkg.sv]
// ---------------------------------------------------------------------------
// Point approach velocity controller package
// Shared types, register indexes and arithmetic constants.
// ---------------------------------------------------------------------------
`default_nettype none

package pavc_pkg;

  // Default parameter values.
  localparam int POS_BITS_DEF = 24;
  localparam int VEL_BITS_DEF = 16;

  // Fixed register field widths.
  localparam int TOL_W  = 16;
  localparam int LIM_W  = 15;
  localparam int TIME_W = 24;
  localparam int IDX_W  = 3;

  // Quotient width of the axis scaling divider; the quotient never exceeds the speed.
  localparam int QUO_W = LIM_W;

  // Control law constants.
  localparam int SPD_FLOOR  = 80;
  localparam int SMALL_DIST = 30;
  localparam int Z_DEAD     = 80;

  // Division by five: floor(y / 5) == (y * RECIP5) >> RECIP5_SH for y below 2^18.
  localparam int RECIP_IN_W = 18;
  localparam logic [19:0] RECIP5 = 20'd838861;
  localparam int RECIP5_SH = 22;
  localparam int RECIP_P_W = RECIP_IN_W + 20;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_TGT_EAST   = 3'd0,
    REG_TGT_NORTH  = 3'd1,
    REG_TGT_UP     = 3'd2,
    REG_HORIZ_TOL  = 3'd3,
    REG_VERT_TOL   = 3'd4,
    REG_HORIZ_LIM  = 3'd5,
    REG_VERT_LIM   = 3'd6,
    REG_TIME_LIMIT = 3'd7
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_REACHED = 2'd1,
    ST_FAILED  = 2'd2
  } status_t;

endpackage

`default_nettype wire

[src/pavc_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// Square root cell
// One restoring step of the floor square root: consumes one bit pair of the
// radicand and produces one root bit, carrying the item's side data along.
// ---------------------------------------------------------------------------
`default_nettype none

module pavc_sqrt_cell
  import pavc_pkg::*;
#(
  parameter int RW = 25,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire logic [2*RW-1:0] in_rad,
  input  wire logic [RW:0]     in_rem,
  input  wire logic [RW-1:0]   in_root,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_v,
  output logic [2*RW-1:0]      out_rad,
  output logic [RW:0]          out_rem,
  output logic [RW-1:0]        out_root,
  output logic [SW-1:0]        out_side
);

  logic            v_r;
  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [SW-1:0]   side_r;
  logic [RW+2:0]   rem2;
  logic [RW+2:0]   trial;

  // Bring down the next bit pair and try the trial subtrahend.
  always_comb begin
    rem2  = {in_rem, in_rad[2*RW-1 -: 2]};
    trial = {1'b0, in_root, 2'b01};
    if (rem2 >= trial) begin
      rem_nxt  = RW'(0) + (RW+1)'(rem2 - trial);
      root_nxt = {in_root[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = (RW+1)'(rem2);
      root_nxt = {in_root[RW-2:0], 1'b0};
    end
    rad_nxt = {in_rad[2*RW-3:0], 2'b00};
  end

  // Valid flag of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

[src/pavc_div_cell.sv]
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step for both horizontal axes at a fixed quotient
// bit position, carrying the divisor and the item's side data along.
// ---------------------------------------------------------------------------
`default_nettype none

module pavc_div_cell
  import pavc_pkg::*;
#(
  parameter int RW = 25,
  parameter int QW = 15,
  parameter int K  = 0,
  parameter int SW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [RW-1:0]    in_dist,
  input  wire logic [RW+QW-1:0] in_rem_x,
  input  wire logic [RW+QW-1:0] in_rem_y,
  input  wire logic [QW-1:0]    in_q_x,
  input  wire logic [QW-1:0]    in_q_y,
  input  wire logic [SW-1:0]    in_side,
  output logic                  out_v,
  output logic [RW-1:0]         out_dist,
  output logic [RW+QW-1:0]      out_rem_x,
  output logic [RW+QW-1:0]      out_rem_y,
  output logic [QW-1:0]         out_q_x,
  output logic [QW-1:0]         out_q_y,
  output logic [SW-1:0]         out_side
);

  localparam int NW = RW + QW;

  logic          v_r;
  logic [RW-1:0] dist_r;
  logic [NW-1:0] rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QW-1:0] q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [SW-1:0] side_r;
  logic [NW-1:0] dsh;
  logic          take_x, take_y;

  // Compare each remainder with the shifted divisor and subtract on success.
  always_comb begin
    dsh       = NW'(in_dist) << K;
    take_x    = in_rem_x >= dsh;
    take_y    = in_rem_y >= dsh;
    rem_x_nxt = take_x ? in_rem_x - dsh : in_rem_x;
    rem_y_nxt = take_y ? in_rem_y - dsh : in_rem_y;
    q_x_nxt   = {in_q_x[QW-2:0], take_x};
    q_y_nxt   = {in_q_y[QW-2:0], take_y};
  end

  // Valid flag of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r  <= in_dist;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
      side_r  <= in_side;
    end
  end

  assign out_v     = v_r;
  assign out_dist  = dist_r;
  assign out_rem_x = rem_x_r;
  assign out_rem_y = rem_y_r;
  assign out_q_x   = q_x_r;
  assign out_q_y   = q_y_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

[src/point_approach_velocity_controller.sv]
// ---------------------------------------------------------------------------
// Point approach velocity controller
// Saturated proportional position-to-velocity controller with arrival and
// timeout detection.
// ---------------------------------------------------------------------------
// The block takes one pose item per clock cycle while in_stall is low and
// returns one result item per input item, in order. The pipeline consists
// of the cell chains: one square root cell per root bit (POS_BITS + 1 cells)
// for the horizontal distance and one divider cell per quotient bit (15
// cells) for the axis scaling, plus three front stages, three speed stages
// and the output register. Input items keep flowing while a result is
// stalled as long as the last divider cell holds no finished item. The user
// must write the configuration registers only while no item is in flight;
// the block itself does not enforce it.
`default_nettype none

`include "point_approach_velocity_controller_defines.svh"

module point_approach_velocity_controller
  import pavc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int VEL_BITS = VEL_BITS_DEF,
  parameter int CFG_W    = (POS_BITS > TIME_W) ? POS_BITS : TIME_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration write port.
  input  wire logic                       cfg_we,
  input  wire logic [IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  // Input channel.
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_pose_valid,
  input  wire logic signed [POS_BITS-1:0] in_pos_east,
  input  wire logic signed [POS_BITS-1:0] in_pos_north,
  input  wire logic signed [POS_BITS-1:0] in_pos_up,
  input  wire logic [TIME_W-1:0]          in_elapsed_ms,
  // Result channel.
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_status,
  output logic                            out_hold_request,
  output logic signed [VEL_BITS-1:0]      out_vel_east,
  output logic signed [VEL_BITS-1:0]      out_vel_north,
  output logic signed [VEL_BITS-1:0]      out_vel_up
);

  localparam int P  = POS_BITS;
  localparam int R  = P + 1;
  localparam int S  = 2 * R;
  localparam int QW = QUO_W;
  localparam int NW = R + QW;
  localparam int MW = (VEL_BITS > 16) ? VEL_BITS : 16;
  localparam logic [MW-1:0] VMAX = MW'((64'd1 << (VEL_BITS - 1)) - 64'd1);
  // Side data through the root chain: pose, timeout, x/y/z signs, z arrival,
  // x and y magnitudes, vertical speed magnitude.
  localparam int SW1 = 6 + 2 * R + LIM_W;
  // Side data through the divider chain adds the xy arrival and small flags.
  localparam int SW2 = SW1 + 2;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [P-1:0]      tgt_e_r, tgt_n_r, tgt_u_r;
  logic [TOL_W-1:0]  htol_r, vtol_r;
  logic [LIM_W-1:0]  hlim_r, vlim_r;
  logic [TIME_W-1:0] tlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_e_r <= '0;
      tgt_n_r <= '0;
      tgt_u_r <= P'(10000);
      htol_r  <= TOL_W'(2000);
      vtol_r  <= TOL_W'(2000);
      hlim_r  <= LIM_W'(4000);
      vlim_r  <= LIM_W'(1000);
      tlim_r  <= TIME_W'(45000);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_TGT_EAST:   tgt_e_r <= cfg_wdata[P-1:0];
        REG_TGT_NORTH:  tgt_n_r <= cfg_wdata[P-1:0];
        REG_TGT_UP:     tgt_u_r <= cfg_wdata[P-1:0];
        REG_HORIZ_TOL:  htol_r  <= cfg_wdata[TOL_W-1:0];
        REG_VERT_TOL:   vtol_r  <= cfg_wdata[TOL_W-1:0];
        REG_HORIZ_LIM:  hlim_r  <= cfg_wdata[LIM_W-1:0];
        REG_VERT_LIM:   vlim_r  <= cfg_wdata[LIM_W-1:0];
        REG_TIME_LIMIT: tlim_r  <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline advance: everything moves unless a result waits in the output
  // register, the sink stalls and another finished item is behind it.
  // -------------------------------------------------------------------------
  logic en;
  logic fin_v;
  logic out_valid_r;

  assign en       = !fin_v || !out_valid_r || !out_stall;
  assign in_stall = !en;

  // -------------------------------------------------------------------------
  // Front stage 0: position errors and timeout flag.
  // -------------------------------------------------------------------------
  logic         s0_v_r, s0_pose_r, s0_to_r;
  logic [R-1:0] s0_dx_r, s0_dy_r, s0_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pose_r <= in_pose_valid;
      s0_to_r   <= in_elapsed_ms > tlim_r;
      s0_dx_r   <= {tgt_e_r[P-1], tgt_e_r} - {in_pos_east[P-1], in_pos_east};
      s0_dy_r   <= {tgt_n_r[P-1], tgt_n_r} - {in_pos_north[P-1], in_pos_north};
      s0_dz_r   <= {tgt_u_r[P-1], tgt_u_r} - {in_pos_up[P-1], in_pos_up};
    end
  end

  // -------------------------------------------------------------------------
  // Front stage 1: magnitudes, squares and the vertical law set-up.
  // -------------------------------------------------------------------------
  logic [R-1:0]          ax, ay, az;
  logic [R+1:0]          y3;
  logic [R+1:0]          vlim5;
  logic                  s1_v_r, s1_pose_r, s1_to_r;
  logic                  s1_sx_r, s1_sy_r, s1_sz_r;
  logic                  s1_zin_r, s1_zdead_r, s1_zfull_r;
  logic [R-1:0]          s1_ax_r, s1_ay_r;
  logic [S-1:0]          s1_sqx_r, s1_sqy_r;
  logic [RECIP_IN_W-1:0] s1_y_r;

  always_comb begin
    ax    = s0_dx_r[P] ? R'(~s0_dx_r + R'(1)) : s0_dx_r;
    ay    = s0_dy_r[P] ? R'(~s0_dy_r + R'(1)) : s0_dy_r;
    az    = s0_dz_r[P] ? R'(~s0_dz_r + R'(1)) : s0_dz_r;
    y3    = (R+2)'(az) * (R+2)'(3);
    vlim5 = (R+2)'(vlim_r) * (R+2)'(5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pose_r  <= s0_pose_r;
      s1_to_r    <= s0_to_r;
      s1_sx_r    <= s0_dx_r[P];
      s1_sy_r    <= s0_dy_r[P];
      s1_sz_r    <= s0_dz_r[P];
      s1_ax_r    <= ax;
      s1_ay_r    <= ay;
      s1_sqx_r   <= S'(ax) * S'(ax);
      s1_sqy_r   <= S'(ay) * S'(ay);
      s1_zin_r   <= az <= R'(vtol_r);
      s1_zdead_r <= az < R'(Z_DEAD);
      s1_zfull_r <= y3 >= vlim5;
      s1_y_r     <= y3[RECIP_IN_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Front stage 2: sum of squares and the divide-by-five product for z.
  // -------------------------------------------------------------------------
  logic                 s2_v_r, s2_pose_r, s2_to_r;
  logic                 s2_sx_r, s2_sy_r, s2_sz_r;
  logic                 s2_zin_r, s2_zdead_r, s2_zfull_r;
  logic [R-1:0]         s2_ax_r, s2_ay_r;
  logic [S-1:0]         s2_sum_r;
  logic [RECIP_P_W-1:0] s2_zp_r;
  logic [LIM_W-1:0]     vz_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pose_r  <= s1_pose_r;
      s2_to_r    <= s1_to_r;
      s2_sx_r    <= s1_sx_r;
      s2_sy_r    <= s1_sy_r;
      s2_sz_r    <= s1_sz_r;
      s2_zin_r   <= s1_zin_r;
      s2_zdead_r <= s1_zdead_r;
      s2_zfull_r <= s1_zfull_r;
      s2_ax_r    <= s1_ax_r;
      s2_ay_r    <= s1_ay_r;
      s2_sum_r   <= s1_sqx_r + s1_sqy_r;
      s2_zp_r    <= RECIP_P_W'(s1_y_r) * RECIP_P_W'(RECIP5);
    end
  end

  // Vertical speed magnitude: dead band, then the limit, else 3/5 of |dz|.
  always_comb begin
    if (s2_zdead_r) begin
      vz_mag = '0;
    end else if (s2_zfull_r) begin
      vz_mag = vlim_r;
    end else begin
      vz_mag = s2_zp_r[RECIP5_SH +: LIM_W];
    end
  end

  // -------------------------------------------------------------------------
  // Square root chain: one cell per root bit.
  // -------------------------------------------------------------------------
  logic           sq_v    [0:R];
  logic [S-1:0]   sq_rad  [0:R];
  logic [R:0]     sq_rem  [0:R];
  logic [R-1:0]   sq_root [0:R];
  logic [SW1-1:0] sq_side [0:R];

  assign sq_v[0]    = s2_v_r;
  assign sq_rad[0]  = s2_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {s2_pose_r, s2_to_r, s2_sx_r, s2_sy_r, s2_sz_r, s2_zin_r,
                       s2_ax_r, s2_ay_r, vz_mag};

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    pavc_sqrt_cell #(
      .RW (R),
      .SW (SW1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (sq_v[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_v    (sq_v[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // -------------------------------------------------------------------------
  // Speed stage A: distance tests and dist * 11 against 20 * limit.
  // -------------------------------------------------------------------------
  logic [R+3:0]          d11;
  logic [R+3:0]          hlim20;
  logic                  sa_v_r, sa_hit_r, sa_tol_r, sa_small_r;
  logic [R-1:0]          sa_dist_r;
  logic [RECIP_IN_W-1:0] sa_y_r;
  logic [SW1-1:0]        sa_side_r;

  assign d11    = (R+4)'(sq_root[R]) * (R+4)'(11);
  assign hlim20 = (R+4)'(hlim_r) * (R+4)'(20);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= sq_v[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dist_r  <= sq_root[R];
      sa_hit_r   <= d11 >= hlim20;
      sa_tol_r   <= sq_root[R] <= R'(htol_r);
      sa_small_r <= sq_root[R] <= R'(SMALL_DIST);
      sa_y_r     <= d11[2 +: RECIP_IN_W];
      sa_side_r  <= sq_side[R];
    end
  end

  // -------------------------------------------------------------------------
  // Speed stage B: divide-by-five product for the proportional speed.
  // -------------------------------------------------------------------------
  logic                 sb_v_r, sb_hit_r, sb_tol_r, sb_small_r;
  logic [R-1:0]         sb_dist_r;
  logic [RECIP_P_W-1:0] sb_p_r;
  logic [SW1-1:0]       sb_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (en) begin
      sb_v_r <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dist_r  <= sa_dist_r;
      sb_hit_r   <= sa_hit_r;
      sb_tol_r   <= sa_tol_r;
      sb_small_r <= sa_small_r;
      sb_p_r     <= RECIP_P_W'(sa_y_r) * RECIP_P_W'(RECIP5);
      sb_side_r  <= sa_side_r;
    end
  end

  // -------------------------------------------------------------------------
  // Speed stage C: clamp the speed and form both numerators.
  // -------------------------------------------------------------------------
  logic [LIM_W-1:0] spd_raw, spd_floor, speed;
  logic [R-1:0]     sb_ax, sb_ay;
  logic             sc_v_r;
  logic [R-1:0]     sc_dist_r;
  logic [NW-1:0]    sc_nx_r, sc_ny_r;
  logic [SW2-1:0]   sc_side_r;

  assign sb_ax = sb_side_r[LIM_W + R +: R];
  assign sb_ay = sb_side_r[LIM_W +: R];

  always_comb begin
    spd_raw   = sb_hit_r ? hlim_r : sb_p_r[RECIP5_SH +: LIM_W];
    spd_floor = (spd_raw < LIM_W'(SPD_FLOOR)) ? LIM_W'(SPD_FLOOR) : spd_raw;
    speed     = (spd_floor > hlim_r) ? hlim_r : spd_floor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r <= sb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_dist_r <= sb_dist_r;
      sc_nx_r   <= NW'(sb_ax) * NW'(speed);
      sc_ny_r   <= NW'(sb_ay) * NW'(speed);
      sc_side_r <= {sb_tol_r, sb_small_r, sb_side_r};
    end
  end

  // -------------------------------------------------------------------------
  // Divider chain: one cell per quotient bit, most significant first.
  // -------------------------------------------------------------------------
  logic           dv_v    [0:QW];
  logic [R-1:0]   dv_dist [0:QW];
  logic [NW-1:0]  dv_rx   [0:QW];
  logic [NW-1:0]  dv_ry   [0:QW];
  logic [QW-1:0]  dv_qx   [0:QW];
  logic [QW-1:0]  dv_qy   [0:QW];
  logic [SW2-1:0] dv_side [0:QW];

  assign dv_v[0]    = sc_v_r;
  assign dv_dist[0] = sc_dist_r;
  assign dv_rx[0]   = sc_nx_r;
  assign dv_ry[0]   = sc_ny_r;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = sc_side_r;

  for (genvar j = 0; j < QW; j++) begin : g_div
    pavc_div_cell #(
      .RW (R),
      .QW (QW),
      .K  (QW - 1 - j),
      .SW (SW2)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_v      (dv_v[j]),
      .in_dist   (dv_dist[j]),
      .in_rem_x  (dv_rx[j]),
      .in_rem_y  (dv_ry[j]),
      .in_q_x    (dv_qx[j]),
      .in_q_y    (dv_qy[j]),
      .in_side   (dv_side[j]),
      .out_v     (dv_v[j+1]),
      .out_dist  (dv_dist[j+1]),
      .out_rem_x (dv_rx[j+1]),
      .out_rem_y (dv_ry[j+1]),
      .out_q_x   (dv_qx[j+1]),
      .out_q_y   (dv_qy[j+1]),
      .out_side  (dv_side[j+1])
    );
  end

  assign fin_v = dv_v[QW];

  // -------------------------------------------------------------------------
  // Result decision and velocity saturation.
  // -------------------------------------------------------------------------
  function automatic logic [VEL_BITS-1:0] sat_vel(input logic neg,
                                                  input logic [LIM_W-1:0] m);
    logic [MW-1:0] mw;
    logic [MW-1:0] ms;
    begin
      mw = MW'(m);
      ms = (mw > VMAX) ? VMAX : mw;
      sat_vel = neg ? VEL_BITS'(~ms + MW'(1)) : VEL_BITS'(ms);
    end
  endfunction

  logic [SW2-1:0]      fs;
  logic                f_tol, f_small, f_pose, f_to, f_sx, f_sy, f_sz, f_zin;
  logic [LIM_W-1:0]    f_vz;
  status_t             st_nxt;
  logic                hold_nxt;
  logic [VEL_BITS-1:0] ve_nxt, vn_nxt, vu_nxt;

  always_comb begin
    fs      = dv_side[QW];
    f_tol   = fs[SW2-1];
    f_small = fs[SW2-2];
    f_pose  = fs[SW1-1];
    f_to    = fs[SW1-2];
    f_sx    = fs[SW1-3];
    f_sy    = fs[SW1-4];
    f_sz    = fs[SW1-5];
    f_zin   = fs[SW1-6];
    f_vz    = fs[LIM_W-1:0];

    st_nxt   = ST_RUNNING;
    hold_nxt = 1'b0;
    ve_nxt   = '0;
    vn_nxt   = '0;
    vu_nxt   = '0;
    if (!f_pose) begin
      st_nxt = f_to ? ST_FAILED : ST_RUNNING;
    end else if (f_tol && f_zin) begin
      st_nxt   = ST_REACHED;
      hold_nxt = 1'b1;
    end else if (f_to) begin
      st_nxt   = ST_FAILED;
      hold_nxt = 1'b1;
    end else begin
      if (!f_small) begin
        ve_nxt = sat_vel(f_sx, dv_qx[QW]);
        vn_nxt = sat_vel(f_sy, dv_qy[QW]);
      end
      vu_nxt = sat_vel(f_sz, f_vz);
    end
  end

  // -------------------------------------------------------------------------
  // Output register.
  // -------------------------------------------------------------------------
  status_t             st_r;
  logic                hold_r;
  logic [VEL_BITS-1:0] ve_r, vn_r, vu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && fin_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_v) begin
      st_r   <= st_nxt;
      hold_r <= hold_nxt;
      ve_r   <= ve_nxt;
      vn_r   <= vn_nxt;
      vu_r   <= vu_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = st_r;
  assign out_hold_request = hold_r;
  assign out_vel_east     = ve_r;
  assign out_vel_north    = vn_r;
  assign out_vel_up       = vu_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `PAVC_ASSERT_NOW(a_hold_zero_vel, clk, rst_n, out_valid_r && hold_r,
                   ve_r == '0 && vn_r == '0 && vu_r == '0)
  `PAVC_ASSERT_NOW(a_reached_holds, clk, rst_n, out_valid_r && st_r == ST_REACHED,
                   hold_r)
  `PAVC_ASSERT_NOW(a_running_no_hold, clk, rst_n, out_valid_r && st_r == ST_RUNNING,
                   !hold_r)
  `PAVC_ASSERT_NEXT(a_finished_loads, clk, rst_n, en && fin_v, out_valid_r)

endmodule

`default_nettype wire
